// ===== hw/rtl/lottery_scheduler_core_macros.svh =====
// ----------------------------------------------------------------------------
// lottery_scheduler_core_macros
// assertion macros for the lottery scheduler rtl
// ----------------------------------------------------------------------------
`ifndef LOTTERY_SCHEDULER_CORE_MACROS_SVH
`define LOTTERY_SCHEDULER_CORE_MACROS_SVH

// property holds in the same cycle
`define LSCHED_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("lsched assertion failed");

// consequent holds in the cycle after the antecedent
`define LSCHED_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lsched assertion failed");

`endif

// ===== hw/rtl/lsched_pkg.sv =====
// ----------------------------------------------------------------------------
// lsched_pkg
// types and constants of the lottery scheduler
// ----------------------------------------------------------------------------
package lsched_pkg;

  localparam logic [2:0] ST_FREE     = 3'd0;
  localparam logic [2:0] ST_RUNNABLE = 3'd1;
  localparam logic [2:0] ST_RUNNING  = 3'd2;
  localparam logic [2:0] ST_DYING    = 3'd4;

  localparam logic [1:0] OUT_RUN     = 2'd0;
  localparam logic [1:0] OUT_RERUN   = 2'd1;
  localparam logic [1:0] OUT_HALT    = 2'd2;
  localparam logic [1:0] OUT_NO_LIVE = 2'd3;

  localparam logic [31:0] LCG_MUL   = 32'd1103515245;
  localparam logic [31:0] LCG_INC   = 32'd12345;
  localparam logic [31:0] LCG_RESET = 32'd1;
  localparam int unsigned DRAW_BITS = 15;

  typedef struct packed {
    logic       req_type;
    logic [9:0] slot_index;
    logic [2:0] slot_status;
    logic [7:0] slot_tickets;
    logic       current_valid;
    logic [9:0] current_slot;
  } lsched_in_t;

  typedef struct packed {
    logic [1:0] outcome;
    logic [9:0] chosen_slot;
  } lsched_out_t;

  typedef struct packed {
    logic       is_sched;
    logic       wr_ok;
    logic       cur_ok;
    logic [9:0] slot_index;
    logic [2:0] slot_status;
    logic [7:0] slot_tickets;
    logic [9:0] current_slot;
  } lsched_cmd_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SUM,
    S_MOD,
    S_WALK,
    S_DONE
  } lsched_state_e;

  function automatic logic is_live(logic [2:0] s);
    return (s == ST_RUNNABLE) || (s == ST_RUNNING);
  endfunction

endpackage

// ===== hw/rtl/lottery_scheduler_core.sv =====
// a write beat is queued and written to the table when the engine pops it
// a schedule beat runs one table sweep for the ticket sum, fifteen modulo
// steps and one lottery walk, all on one ram read port
// up to two beats queue ahead of the engine, results sit in an output register
// after reset a clearing pass over every slot runs while no beat is accepted
// ----------------------------------------------------------------------------
// lottery_scheduler_core
// lottery scheduler top level: request queue front and table engine back
// ----------------------------------------------------------------------------
module lottery_scheduler_core #(
  parameter int SLOTS       = 1024,
  parameter int TICKET_BITS = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  lsched_pkg::lsched_in_t  in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output lsched_pkg::lsched_out_t out_data_o
);

  logic                    busy;
  logic                    q_valid;
  logic                    q_pop;
  lsched_pkg::lsched_cmd_t q_data;

  lsched_front #(.SLOTS(SLOTS)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i (in_data_i),
    .busy_i    (busy),
    .q_valid_o (q_valid),
    .q_data_o  (q_data),
    .q_pop_i   (q_pop)
  );

  lsched_back #(.SLOTS(SLOTS), .TICKET_BITS(TICKET_BITS)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_data_i   (q_data),
    .q_pop_o    (q_pop),
    .busy_o     (busy),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

// ===== hw/rtl/lsched_ram.sv =====
// ----------------------------------------------------------------------------
// lsched_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module lsched_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/lsched_front.sv =====
// ----------------------------------------------------------------------------
// lsched_front
// accepts request beats, classifies them and queues them for the engine
// ----------------------------------------------------------------------------
module lsched_front #(
  parameter int SLOTS = 1024
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  lsched_pkg::lsched_in_t  in_data_i,
  input  logic                    busy_i,
  output logic                    q_valid_o,
  output lsched_pkg::lsched_cmd_t q_data_o,
  input  logic                    q_pop_i
);

  lsched_pkg::lsched_cmd_t buf_q [2];
  logic                    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0]              cnt_q, cnt_d;
  logic                    push;
  lsched_pkg::lsched_cmd_t cmd;

  always_comb begin
    cmd.is_sched     = in_data_i.req_type;
    cmd.wr_ok        = 32'(in_data_i.slot_index) < 32'(SLOTS);
    cmd.cur_ok       = in_data_i.current_valid && (32'(in_data_i.current_slot) < 32'(SLOTS));
    cmd.slot_index   = in_data_i.slot_index;
    cmd.slot_status  = in_data_i.slot_status;
    cmd.slot_tickets = in_data_i.slot_tickets;
    cmd.current_slot = in_data_i.current_slot;
  end

  assign in_ready_o = (cnt_q != 2'd2) && !busy_i;
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = cnt_q != 2'd0;
  assign q_data_o   = buf_q[rptr_q];

  always_comb begin
    wptr_d = push ? !wptr_q : wptr_q;
    rptr_d = q_pop_i ? !rptr_q : rptr_q;
    cnt_d  = cnt_q + {1'b0, push} - {1'b0, q_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wptr_q] <= cmd;
    end
  end

endmodule

// ===== hw/rtl/lsched_back.sv =====
// ----------------------------------------------------------------------------
// lsched_back
// slot table engine: clear pass, writes, ticket sum, modulo and lottery walk
// ----------------------------------------------------------------------------
`include "lottery_scheduler_core_macros.svh"

module lsched_back #(
  parameter int SLOTS       = 1024,
  parameter int TICKET_BITS = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    q_valid_i,
  input  lsched_pkg::lsched_cmd_t q_data_i,
  output logic                    q_pop_o,
  output logic                    busy_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output lsched_pkg::lsched_out_t out_data_o
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = IW + 1;
  localparam int SW = TICKET_BITS + IW + 1;
  localparam int DW = 3 + TICKET_BITS;

  lsched_pkg::lsched_state_e state_q, state_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [IW-1:0]          addr_q, addr_d;
  logic                   rd_v_q, rd_v_d;
  logic [IW-1:0]          rd_a_q, rd_a_d;
  logic [SW-1:0]          total_q, total_d;
  logic                   any_q, any_d;
  logic                   cur_run_q, cur_run_d;
  logic                   cur_ok_q, cur_ok_d;
  logic [IW-1:0]          cur_q, cur_d;
  logic [SW-1:0]          r_q, r_d;
  logic [3:0]             bit_q, bit_d;
  logic [SW-1:0]          acc_q, acc_d;
  logic                   found_q, found_d;
  logic [IW-1:0]          pick_q, pick_d;
  logic [31:0]            lcg_q, lcg_d;
  logic                   out_valid_q, out_valid_d;
  lsched_pkg::lsched_out_t out_q, out_d;

  logic                   we;
  logic [IW-1:0]          waddr, raddr;
  logic [DW-1:0]          wdata, rdata;
  logic [2:0]             r_st;
  logic [SW-1:0]          r_tk;
  logic [14:0]            draw;
  logic [SW:0]            r_sh;
  logic [SW-1:0]          acc_sum;

  lsched_ram #(.WIDTH(DW), .DEPTH(SLOTS)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign r_st    = rdata[DW-1:TICKET_BITS];
  assign r_tk    = SW'(rdata[TICKET_BITS-1:0]);
  assign draw    = lcg_q[30:16];
  assign r_sh    = {r_q, draw[bit_q]};
  assign acc_sum = acc_q + r_tk;

  assign busy_o      = state_q == lsched_pkg::S_CLEAR;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    addr_d      = addr_q;
    rd_v_d      = 1'b0;
    total_d     = total_q;
    any_d       = any_q;
    cur_run_d   = cur_run_q;
    cur_ok_d    = cur_ok_q;
    cur_d       = cur_q;
    r_d         = r_q;
    bit_d       = bit_q;
    acc_d       = acc_q;
    found_d     = found_q;
    pick_d      = pick_q;
    lcg_d       = lcg_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    q_pop_o     = 1'b0;
    we          = 1'b0;
    waddr       = cnt_q[IW-1:0];
    wdata       = '0;
    raddr       = cnt_q[IW-1:0];

    case (state_q)
      lsched_pkg::S_CLEAR: begin
        we    = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q[IW-1:0] == IW'(SLOTS - 1)) begin
          state_d = lsched_pkg::S_IDLE;
        end
      end
      lsched_pkg::S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (!q_data_i.is_sched) begin
            we    = q_data_i.wr_ok;
            waddr = IW'(q_data_i.slot_index);
            wdata = {q_data_i.slot_status, TICKET_BITS'(q_data_i.slot_tickets)};
          end else begin
            cnt_d     = '0;
            total_d   = '0;
            any_d     = 1'b0;
            cur_run_d = 1'b0;
            found_d   = 1'b0;
            cur_ok_d  = q_data_i.cur_ok;
            cur_d     = IW'(q_data_i.current_slot);
            lcg_d     = lcg_q * lsched_pkg::LCG_MUL + lsched_pkg::LCG_INC;
            state_d   = lsched_pkg::S_SUM;
          end
        end
      end
      lsched_pkg::S_SUM: begin
        if (cnt_q != CW'(SLOTS)) begin
          rd_v_d = 1'b1;
          cnt_d  = cnt_q + 1'b1;
        end
        if (rd_v_q) begin
          if (lsched_pkg::is_live(r_st)) begin
            total_d = total_q + r_tk;
          end
          if (lsched_pkg::is_live(r_st) || r_st == lsched_pkg::ST_DYING) begin
            any_d = 1'b1;
          end
          if (rd_a_q == cur_q && r_st == lsched_pkg::ST_RUNNING) begin
            cur_run_d = 1'b1;
          end
        end
        if (cnt_q == CW'(SLOTS) && !rd_v_q) begin
          r_d     = '0;
          bit_d   = 4'(lsched_pkg::DRAW_BITS - 1);
          state_d = (total_q == '0) ? lsched_pkg::S_DONE : lsched_pkg::S_MOD;
        end
      end
      lsched_pkg::S_MOD: begin
        r_d   = (r_sh >= {1'b0, total_q}) ? SW'(r_sh - {1'b0, total_q}) : SW'(r_sh);
        bit_d = bit_q - 1'b1;
        if (bit_q == 4'd0) begin
          cnt_d   = '0;
          acc_d   = '0;
          addr_d  = (cur_ok_q && cur_q != IW'(SLOTS - 1)) ? cur_q + 1'b1 : '0;
          state_d = lsched_pkg::S_WALK;
        end
      end
      lsched_pkg::S_WALK: begin
        raddr = addr_q;
        if (cnt_q != CW'(SLOTS) && !found_q) begin
          rd_v_d = 1'b1;
          cnt_d  = cnt_q + 1'b1;
          addr_d = (addr_q == IW'(SLOTS - 1)) ? '0 : addr_q + 1'b1;
        end
        if (rd_v_q && !found_q && lsched_pkg::is_live(r_st)) begin
          acc_d = acc_sum;
          if (acc_sum > r_q) begin
            found_d = 1'b1;
            pick_d  = rd_a_q;
          end
        end
        if (found_q || (cnt_q == CW'(SLOTS) && !rd_v_q)) begin
          state_d = lsched_pkg::S_DONE;
        end
      end
      lsched_pkg::S_DONE: begin
        if (!out_valid_q) begin
          out_valid_d = 1'b1;
          state_d     = lsched_pkg::S_IDLE;
          if (found_q) begin
            out_d.outcome     = lsched_pkg::OUT_RUN;
            out_d.chosen_slot = 10'(pick_q);
          end else if (cur_ok_q && cur_run_q) begin
            out_d.outcome     = lsched_pkg::OUT_RERUN;
            out_d.chosen_slot = 10'(cur_q);
          end else begin
            out_d.outcome     = any_q ? lsched_pkg::OUT_HALT : lsched_pkg::OUT_NO_LIVE;
            out_d.chosen_slot = '0;
          end
        end
      end
      default: begin
        state_d = lsched_pkg::S_IDLE;
      end
    endcase
    rd_a_d = raddr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lsched_pkg::S_CLEAR;
      cnt_q       <= '0;
      addr_q      <= '0;
      rd_v_q      <= 1'b0;
      rd_a_q      <= '0;
      total_q     <= '0;
      any_q       <= 1'b0;
      cur_run_q   <= 1'b0;
      cur_ok_q    <= 1'b0;
      cur_q       <= '0;
      r_q         <= '0;
      bit_q       <= '0;
      acc_q       <= '0;
      found_q     <= 1'b0;
      pick_q      <= '0;
      lcg_q       <= lsched_pkg::LCG_RESET;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      addr_q      <= addr_d;
      rd_v_q      <= rd_v_d;
      rd_a_q      <= rd_a_d;
      total_q     <= total_d;
      any_q       <= any_d;
      cur_run_q   <= cur_run_d;
      cur_ok_q    <= cur_ok_d;
      cur_q       <= cur_d;
      r_q         <= r_d;
      bit_q       <= bit_d;
      acc_q       <= acc_d;
      found_q     <= found_d;
      pick_q      <= pick_d;
      lcg_q       <= lcg_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  `LSCHED_ASSERT(a_pop_needs_valid, clk_i, rst_ni, !q_pop_o || q_valid_i)
  `LSCHED_ASSERT(a_no_out_in_clear, clk_i, rst_ni, !(busy_o && out_valid_q))
  `LSCHED_ASSERT(a_rem_below_total, clk_i, rst_ni, state_q != lsched_pkg::S_WALK || r_q < total_q)
  `LSCHED_ASSERT_NEXT(a_walk_found_done, clk_i, rst_ni,
                      state_q == lsched_pkg::S_WALK && found_q, state_q == lsched_pkg::S_DONE)

endmodule

// ===== tb/sv/lottery_scheduler_core_tb.sv =====
// ----------------------------------------------------------------------------
// lottery_scheduler_core_tb
// self-checking bench: slot writes and lottery draws are mirrored in a local
// table and lcg, every schedule beat's outcome and slot is checked in order,
// with bursty input, random output stalls and one long output hold-off
// ----------------------------------------------------------------------------
module lottery_scheduler_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOTS     = 1024;
  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_LEN   = 3000;
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_SCHED = 1'b1;
  localparam logic [2:0] ST_NOT_RUNNABLE = 3'd3;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  lsched_pkg::lsched_in_t  in_data_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  lsched_pkg::lsched_out_t out_data_o;

  lottery_scheduler_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  logic [2:0]              status_mirror [NSLOTS];
  logic [7:0]              ticket_mirror [NSLOTS];
  logic [31:0]             lcg_mirror;
  lsched_pkg::lsched_out_t decisions_due[$];
  bit                      failed;
  bit                      hold_req;
  int                      burst_left;
  int                      idle_cycles;
  logic [9:0]              pool[16];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic lsched_pkg::lsched_out_t draw_decision(logic cur_ok_in, logic [9:0] cur);
    lsched_pkg::lsched_out_t res;
    logic [31:0] total, winner, acc;
    logic [9:0]  j;
    bit          found, any;
    total = 0;
    acc   = 0;
    found = 0;
    any   = 0;
    res   = '0;
    for (int k = 0; k < NSLOTS; k++) begin
      if (status_mirror[k] == lsched_pkg::ST_RUNNABLE ||
          status_mirror[k] == lsched_pkg::ST_RUNNING) begin
        total += ticket_mirror[k];
      end
    end
    lcg_mirror = lcg_mirror * lsched_pkg::LCG_MUL + lsched_pkg::LCG_INC;
    winner = (lcg_mirror >> 16) & 32'h7fff;
    if (total != 0) begin
      winner = winner % total + 1;
      j = cur_ok_in ? cur + 10'd1 : 10'd0;
      for (int k = 0; k < NSLOTS && !found; k++) begin
        if (status_mirror[j] == lsched_pkg::ST_RUNNABLE ||
            status_mirror[j] == lsched_pkg::ST_RUNNING) begin
          acc += ticket_mirror[j];
          if (acc >= winner) begin
            found = 1;
            res.outcome = lsched_pkg::OUT_RUN;
            res.chosen_slot = j;
          end
        end
        j = j + 10'd1;
      end
    end
    if (found) return res;
    if (cur_ok_in && status_mirror[cur] == lsched_pkg::ST_RUNNING) begin
      res.outcome = lsched_pkg::OUT_RERUN;
      res.chosen_slot = cur;
      return res;
    end
    for (int k = 0; k < NSLOTS; k++) begin
      if (status_mirror[k] == lsched_pkg::ST_RUNNABLE ||
          status_mirror[k] == lsched_pkg::ST_RUNNING ||
          status_mirror[k] == lsched_pkg::ST_DYING) begin
        any = 1;
      end
    end
    res.outcome = any ? lsched_pkg::OUT_HALT : lsched_pkg::OUT_NO_LIVE;
    return res;
  endfunction

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_beat(logic req, logic [9:0] idx, logic [2:0] st, logic [7:0] tk,
                           logic cv, logic [9:0] cs);
    lsched_pkg::lsched_in_t beat;
    int gap;
    beat = '{req, idx, st, tk, cv, cs};
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (!in_ready_o);
    if (req == REQ_WRITE) begin
      status_mirror[idx] = st;
      ticket_mirror[idx] = tk;
    end else begin
      decisions_due.push_back(draw_decision(cv, cs));
    end
    @(negedge clk_i);
  endtask

  task automatic wipe_live();
    for (int k = 0; k < NSLOTS; k++) begin
      if (status_mirror[k] != lsched_pkg::ST_FREE) begin
        send_beat(REQ_WRITE, 10'(k), lsched_pkg::ST_FREE, 8'd0, 1'b0, 10'd0);
      end
    end
  endtask

  task automatic test_empty_table();
    send_beat(REQ_SCHED, 10'd0, 3'd0, 8'd0, 1'b0, 10'd0);
    send_beat(REQ_SCHED, 10'd0, 3'd0, 8'd0, 1'b1, 10'd1023);
  endtask

  task automatic test_extremes();
    send_beat(REQ_WRITE, 10'd0, lsched_pkg::ST_RUNNABLE, 8'd255, 1'b0, 10'd0);
    send_beat(REQ_WRITE, 10'd1023, lsched_pkg::ST_RUNNING, 8'd1, 1'b0, 10'd0);
    send_beat(REQ_WRITE, 10'd512, ST_NOT_RUNNABLE, 8'd200, 1'b0, 10'd0);
    send_beat(REQ_WRITE, 10'd513, 3'd7, 8'd170, 1'b0, 10'd0);
    send_beat(REQ_WRITE, 10'd514, 3'd5, 8'd85, 1'b0, 10'd0);
    send_beat(REQ_SCHED, 10'h3ff, 3'd7, 8'hff, 1'b1, 10'd1023);
    send_beat(REQ_SCHED, 10'd0, 3'd0, 8'd0, 1'b0, 10'd512);
    send_beat(REQ_SCHED, 10'd0, 3'd0, 8'd0, 1'b1, 10'd0);
    wipe_live();
  endtask

  task automatic test_halt_and_rerun();
    send_beat(REQ_WRITE, 10'd5, lsched_pkg::ST_DYING, 8'd50, 1'b0, 10'd0);
    send_beat(REQ_WRITE, 10'd6, 3'd6, 8'd10, 1'b0, 10'd0);
    send_beat(REQ_SCHED, 10'd0, 3'd0, 8'd0, 1'b1, 10'd5);
    send_beat(REQ_WRITE, 10'd9, lsched_pkg::ST_RUNNING, 8'd0, 1'b0, 10'd0);
    send_beat(REQ_SCHED, 10'd0, 3'd0, 8'd0, 1'b1, 10'd9);
    send_beat(REQ_SCHED, 10'd0, 3'd0, 8'd0, 1'b0, 10'd9);
    send_beat(REQ_WRITE, 10'd5, lsched_pkg::ST_FREE, 8'd0, 1'b0, 10'd0);
    send_beat(REQ_WRITE, 10'd9, ST_NOT_RUNNABLE, 8'd0, 1'b0, 10'd0);
    send_beat(REQ_SCHED, 10'd0, 3'd0, 8'd0, 1'b1, 10'd9);
    wipe_live();
  endtask

  task automatic random_beat(int sched_pct);
    logic [9:0] idx, cs;
    logic [2:0] st;
    idx = ($urandom_range(0, 9) < 8) ? pool[$urandom_range(0, 15)] : 10'($urandom);
    cs  = ($urandom_range(0, 3) < 3) ? pool[$urandom_range(0, 15)] : 10'($urandom);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: st = lsched_pkg::ST_RUNNABLE;
      4, 5:       st = lsched_pkg::ST_RUNNING;
      6:          st = lsched_pkg::ST_DYING;
      7:          st = lsched_pkg::ST_FREE;
      default:    st = 3'($urandom_range(3, 7));
    endcase
    if ($urandom_range(0, 99) < sched_pct) begin
      send_beat(REQ_SCHED, 10'($urandom), 3'($urandom), 8'($urandom),
                1'($urandom), cs);
    end else begin
      send_beat(REQ_WRITE, idx, st, 8'($urandom), 1'($urandom), 10'($urandom));
    end
  endtask

  task automatic test_random_mix();
    for (int k = 0; k < 16; k++) pool[k] = 10'($urandom);
    pool[0] = 10'd1023;
    pool[1] = 10'd0;
    for (int n = 0; n < 240; n++) random_beat(30);
  endtask

  task automatic test_output_hold();
    hold_req = 1;
    for (int n = 0; n < 14; n++) random_beat(60);
  endtask

  always @(posedge clk_i) begin
    lsched_pkg::lsched_out_t exp_d;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (decisions_due.size() == 0) begin
        $error("unexpected decision outcome %0d slot %0d",
               out_data_o.outcome, out_data_o.chosen_slot);
        failed = 1;
      end else begin
        exp_d = decisions_due.pop_front();
        if (out_data_o.outcome !== exp_d.outcome) begin
          $error("outcome exp %0d got %0d", exp_d.outcome, out_data_o.outcome);
          failed = 1;
        end
        if (out_data_o.chosen_slot !== exp_d.chosen_slot) begin
          $error("chosen_slot exp %0d got %0d", exp_d.chosen_slot, out_data_o.chosen_slot);
          failed = 1;
        end
      end
    end
  end

  initial begin
    int phase;
    phase = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_LEN) @(negedge clk_i);
        hold_req = 0;
      end
      phase++;
      case ((phase / 300) % 3)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= 1'($urandom_range(0, 1));
        default: out_ready_i <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("** lottery_scheduler_core: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    failed      = 0;
    hold_req    = 0;
    burst_left  = 0;
    idle_cycles = 0;
    for (int k = 0; k < NSLOTS; k++) begin
      status_mirror[k] = lsched_pkg::ST_FREE;
      ticket_mirror[k] = 8'd0;
    end
    lcg_mirror = lsched_pkg::LCG_RESET;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_empty_table();
    test_extremes();
    test_halt_and_rerun();
    test_random_mix();
    test_output_hold();
    in_valid_i <= 1'b0;
    while (decisions_due.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (!failed) begin
      $display("** lottery_scheduler_core: PASSED **");
    end else begin
      $display("** lottery_scheduler_core: FAILED **");
    end
    $finish;
  end

endmodule
